// ===== design/stips_pkg.sv =====
// Shared constants and command codes for the sorted table insert position search unit.
// No dependencies; every other file in the design but stips_key_ram.sv imports this package.
package stips_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 10;
  localparam int POS_W       = 11;
  localparam int CFG_W       = 11;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

endpackage

// ===== design/stips_channels.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on stips_pkg for field widths.
interface stips_req_if import stips_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] key_value;

  modport source(output valid, cmd, entry_index, key_value, input ready);
  modport sink(input valid, cmd, entry_index, key_value, output ready);
endinterface

interface stips_rsp_if import stips_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             found;

  modport source(output valid, position, found, input ready);
  modport sink(input valid, position, found, output ready);
endinterface

// ===== design/sorted_table_insert_position_search_unit.sv =====
// Top level of the sorted table insert position search unit.
// Depends on stips_pkg, stips_channels.sv, stips_key_ram and stips_search_ctrl.
//
// Items arrive on the req channel and results leave on the rsp channel; each moves by a
// valid/ready transfer. A load item (cmd 0) writes key_value at entry_index and gives no
// result. A search item (cmd 1) runs a binary search over the first entries_in_use keys
// and gives one result: the matching index with found set, or the insertion position
// with found clear.
// The search performs one key RAM read per cycle, so a search over n entries needs at
// most ceil(log2(n+1)) probes, eleven for 1024 entries. After the last probe the search
// state passes through S_FINISH to the output register, and the unit is ready for the next
// item in the same cycle that the result is presented, not before the last item is done.
// The user must write entries_in_use through cfg_wr_en and cfg_wr_data only while the
// unit is idle; the unit does not enforce it. Counts over the depth saturate to the depth.
// Reset clears the count and the control state; the key table holds nothing defined
// until keys are loaded. If the receiver stalls, the pending result is held in the
// output register and further loads are still accepted; a finished search waits until
// the output register is free.
module sorted_table_insert_position_search_unit import stips_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  stips_req_if.sink        req,
  stips_rsp_if.source      rsp,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0]  entries_in_use;
  logic [CNT_W-1:0]  entry_count;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_wr_en) begin
      entries_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
      entry_count = CNT_W'(TABLE_DEPTH);
    end else begin
      entry_count = CNT_W'(entries_in_use);
    end
  end

  stips_key_ram #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (KEY_W),
    .ADDR_W (ADDR_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stips_search_ctrl u_search_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .entry_count (entry_count),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

endmodule

// ===== design/stips_key_ram.sv =====
// Generic simple dual-port synchronous RAM with one write and one registered read port.
// No package dependencies.
module stips_key_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/stips_search_ctrl.sv =====
// Sequencer that writes loaded keys and runs the binary search against the key RAM.
// Depends on stips_pkg and the channel interfaces in stips_channels.sv.
module stips_search_ctrl import stips_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  stips_req_if.sink          req,
  stips_rsp_if.source        rsp,
  input  logic [CNT_W-1:0]   entry_count,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [KEY_W-1:0]   wr_data,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [KEY_W-1:0]   rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINISH} state_t;

  state_t                  state;
  logic signed [KEY_W-1:0] target;
  logic [CNT_W-1:0]        low;
  logic [CNT_W-1:0]        high;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        pos;
  logic                    hit;
  logic                    out_valid;
  logic [POS_W-1:0]        out_position;
  logic                    out_found;

  logic signed [KEY_W-1:0] probe;
  logic                    go_right;
  logic                    go_left;
  logic [CNT_W-1:0]        mid_plus;
  logic [CNT_W-1:0]        mid_right;
  logic [CNT_W-1:0]        mid_left;
  logic [CNT_W-1:0]        mid_first;
  logic [CNT_W-1:0]        mid_next;
  logic                    load_ok;

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.position = out_position;
  assign rsp.found    = out_found;

  assign load_ok = (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign wr_en   = req.valid && req.ready && (req.cmd == CMD_LOAD) && load_ok;
  assign wr_addr = ADDR_W'(req.entry_index);
  assign wr_data = req.key_value;

  always_comb begin
    probe     = signed'(rd_data);
    go_right  = target > probe;
    go_left   = target < probe;
    mid_plus  = mid + CNT_W'(1);
    mid_right = mid_plus + ((high - mid - CNT_W'(2)) >> 1);
    mid_left  = low + ((mid - low - CNT_W'(1)) >> 1);
    mid_first = (entry_count - CNT_W'(1)) >> 1;
    case (state)
      S_IDLE:   mid_next = mid_first;
      S_SEARCH: mid_next = go_right ? mid_right : mid_left;
      default:  mid_next = mid;
    endcase
    rd_addr = mid_next[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && (req.cmd == CMD_SEARCH)) begin
            target <= req.key_value;
            low    <= '0;
            high   <= entry_count;
            mid    <= mid_first;
            if (entry_count == '0) begin
              pos   <= '0;
              hit   <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (go_right) begin
            if (mid_plus < high) begin
              low <= mid_plus;
              mid <= mid_right;
            end else begin
              pos   <= mid_plus;
              hit   <= 1'b0;
              state <= S_FINISH;
            end
          end else if (go_left) begin
            if (low < mid) begin
              high <= mid;
              mid  <= mid_left;
            end else begin
              pos   <= low;
              hit   <= 1'b0;
              state <= S_FINISH;
            end
          end else begin
            pos   <= mid;
            hit   <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_position <= POS_W'(pos);
            out_found    <= hit;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
